### rtl/core/rne_pkg.sv
// Shared types, constants and letter helpers of the Roman numeral encoder.
`default_nettype none
package rne_pkg;

   // Input range and queue sizing
   localparam int          VALUE_W       = 12;
   localparam int          LETTER_W      = 7;
   localparam int          DIGIT_COUNT   = 4;
   localparam int          QUEUE_DEPTH   = 2;
   localparam logic [11:0] VALUE_MAX     = 12'd3999;

   // ASCII codes of the numeral letters
   localparam logic [6:0] CHAR_I    = 7'h49;
   localparam logic [6:0] CHAR_V    = 7'h56;
   localparam logic [6:0] CHAR_X    = 7'h58;
   localparam logic [6:0] CHAR_L    = 7'h4C;
   localparam logic [6:0] CHAR_C    = 7'h43;
   localparam logic [6:0] CHAR_D    = 7'h44;
   localparam logic [6:0] CHAR_M    = 7'h4D;
   localparam logic [6:0] CHAR_NONE = 7'h00;

   // One classified item handed from front to back
   typedef struct packed {
      logic             empty;
      logic             err;
      logic [3:0][3:0]  digit;   // BCD, digit[3] = thousands
   } rne_entry_type;

   // Letter table: 0..6 = I V X L C D M, 7 = none
   function automatic logic [6:0] letter_code(input logic [2:0] idx);
      logic [6:0] code;
      case (idx)
         3'd0:    code = CHAR_I;
         3'd1:    code = CHAR_V;
         3'd2:    code = CHAR_X;
         3'd3:    code = CHAR_L;
         3'd4:    code = CHAR_C;
         3'd5:    code = CHAR_D;
         3'd6:    code = CHAR_M;
         default: code = CHAR_NONE;
      endcase
      return code;
   endfunction

   // Number of letters one decimal digit produces
   function automatic logic [2:0] digit_len(input logic [3:0] d);
      logic [2:0] len;
      case (d)
         4'd1:    len = 3'd1;
         4'd2:    len = 3'd2;
         4'd3:    len = 3'd3;
         4'd4:    len = 3'd2;
         4'd5:    len = 3'd1;
         4'd6:    len = 3'd2;
         4'd7:    len = 3'd3;
         4'd8:    len = 3'd4;
         4'd9:    len = 3'd2;
         default: len = 3'd0;
      endcase
      return len;
   endfunction

   // Table index of letter 'step' of digit d at decimal position pos
   function automatic logic [2:0] letter_index(input logic [3:0] d,
                                               input logic [1:0] step,
                                               input logic [1:0] pos);
      logic [2:0] one;
      logic [2:0] idx;
      one = {pos, 1'b0};
      if (d == 4'd9) begin
         idx = (step == 2'd0) ? one : one + 3'd2;
      end else if (d >= 4'd5) begin
         idx = (step == 2'd0) ? one + 3'd1 : one;
      end else if (d == 4'd4) begin
         idx = (step == 2'd0) ? one : one + 3'd1;
      end else begin
         idx = one;
      end
      return idx;
   endfunction

endpackage
`default_nettype wire

### rtl/core/roman_numeral_encoder_unit.sv
// Top level of the Roman numeral encoder: front, queue and back.
//
// Usage: req_value (0..3999) is taken on a req beat (req_valid high, req_stall
// low). Each accepted value yields a run of rsp beats, one ASCII letter each
// (I V X L C D M), thousands first, rsp_last set on the final letter.
// Zero yields one beat with rsp_empty_res set; a value above 3999 yields one
// beat with rsp_out_of_range set; both carry letter 0 and rsp_last.
// Path: the front runs a bit-per-cycle binary to BCD conversion and then
// pushes the entry into the queue; the back loads it from the queue and steps
// over any leading zero digits before the first beat appears.
// Pacing: the front takes no new value until it has pushed the last one; the
// back emits one letter per cycle while rsp_stall is low, but emits nothing
// while it loads an entry or steps over a zero digit above the last letter.
// The slower of the two sets the sustained rate.
// Reset clears all control state; no beat is in flight afterwards.
// When rsp_stall is high the result register holds its beat, the back waits,
// the queue fills and the front then holds req_stall high.
`default_nettype none
module roman_numeral_encoder_unit import rne_pkg::*; #(
   parameter int QueueDepth = QUEUE_DEPTH
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_stall,
   input  wire logic [VALUE_W-1:0]   req_value,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   output      logic [LETTER_W-1:0]  rsp_letter,
   output      logic                 rsp_last,
   output      logic                 rsp_empty_res,
   output      logic                 rsp_out_of_range
);

   logic           push_valid;
   rne_entry_type  push_data;
   logic           push_full;
   logic           pop;
   logic           pop_valid;
   rne_entry_type  pop_data;

   rne_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_value  (req_value),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_full  (push_full)
   );

   rne_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_full  (push_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data)
   );

   rne_back u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (pop_valid),
      .pop_data         (pop_data),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_letter       (rsp_letter),
      .rsp_last         (rsp_last),
      .rsp_empty_res    (rsp_empty_res),
      .rsp_out_of_range (rsp_out_of_range)
   );

`ifndef SYNTHESIS
   // Front is busy converting right after taking a beat
   a_front_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("front took a beat without going busy");

   // Empty and error flags never appear together
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_empty_res && rsp_out_of_range))
      else $error("empty and out-of-range both set");

   // A flagged beat is a lone, letterless beat
   a_flag_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_empty_res || rsp_out_of_range)
         |-> rsp_last && (rsp_letter == CHAR_NONE))
      else $error("flagged beat carries a letter or is not last");

   // A letter beat always carries a numeral letter
   a_letter_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_empty_res && !rsp_out_of_range |-> rsp_letter != CHAR_NONE)
      else $error("letter beat without a letter");
`endif

endmodule
`default_nettype wire

### rtl/core/rne_front.sv
// Front end: accepts a value, classifies it and converts it to BCD digits.
`default_nettype none
module rne_front import rne_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire logic [VALUE_W-1:0]  req_value,
   output      logic                push_valid,
   output      rne_entry_type       push_data,
   input  wire logic                push_full
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_PUSH = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [3:0]          cnt_ff, cnt_in;
   logic [VALUE_W-1:0]  bin_ff, bin_in;
   logic [15:0]         bcd_ff, bcd_in;
   logic                empty_ff, empty_in;
   logic                err_ff, err_in;
   logic [15:0]         bcd_adj;
   logic                accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // Double-dabble correction: add 3 to every digit of 5 or more
   always_comb begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         bcd_adj[i*4 +: 4] = (bcd_ff[i*4 +: 4] >= 4'd5) ? bcd_ff[i*4 +: 4] + 4'd3
                                                         : bcd_ff[i*4 +: 4];
      end
   end

   // Sequencer: one input bit shifted into the BCD word per cycle
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      empty_in = empty_ff;
      err_in   = err_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_CONV;
               cnt_in   = 4'd0;
               bin_in   = req_value;
               bcd_in   = 16'd0;
               empty_in = (req_value == '0);
               err_in   = (req_value > VALUE_MAX);
            end
         end
         ST_CONV: begin
            bcd_in = {bcd_adj[14:0], bin_ff[VALUE_W-1]};
            bin_in = {bin_ff[VALUE_W-2:0], 1'b0};
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'(VALUE_W - 1)) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (!push_full) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign push_valid      = (state_ff == ST_PUSH) && !push_full;
   assign push_data.empty = empty_ff;
   assign push_data.err   = err_ff;
   assign push_data.digit = bcd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff   <= cnt_in;
      bin_ff   <= bin_in;
      bcd_ff   <= bcd_in;
      empty_ff <= empty_in;
      err_ff   <= err_in;
   end

endmodule
`default_nettype wire

### rtl/core/rne_queue.sv
// Short queue of classified entries between front and back.
`default_nettype none
module rne_queue import rne_pkg::*; #(
   parameter int Depth = QUEUE_DEPTH
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push_valid,
   input  wire rne_entry_type  push_data,
   output      logic           push_full,
   input  wire logic           pop,
   output      logic           pop_valid,
   output      rne_entry_type  pop_data
);

   localparam int PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CNT_W = $clog2(Depth + 1);

   rne_entry_type     slot_ff [Depth];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign push_full = (count_ff == CNT_W'(Depth));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];
   assign do_push   = push_valid && !push_full;
   assign do_pop    = pop && pop_valid;

   // Pointer and fill-count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

### rtl/core/rne_back.sv
// Back end: walks the BCD digits and emits one numeral letter per beat, or one flagged beat.
`default_nettype none
module rne_back import rne_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 pop_valid,
   input  wire rne_entry_type        pop_data,
   output      logic                 pop,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   output      logic [LETTER_W-1:0]  rsp_letter,
   output      logic                 rsp_last,
   output      logic                 rsp_empty_res,
   output      logic                 rsp_out_of_range
);

   logic                 busy_ff, busy_in;
   rne_entry_type        ent_ff, ent_in;
   logic [1:0]           pos_ff, pos_in;
   logic [1:0]           step_ff, step_in;
   logic                 valid_ff, valid_in;
   logic [LETTER_W-1:0]  letter_ff, letter_in;
   logic                 last_ff, last_in;
   logic                 empty_ff, empty_in;
   logic                 err_ff, err_in;

   logic [3:0]           cur_d;
   logic [2:0]           cur_len;
   logic                 lower_nz;
   logic                 digit_end;
   logic                 out_free;

   assign cur_d     = ent_ff.digit[pos_ff];
   assign cur_len   = digit_len(cur_d);
   assign digit_end = ({1'b0, step_ff} == cur_len - 3'd1);
   assign out_free  = !valid_ff || !rsp_stall;
   assign pop       = !busy_ff && pop_valid;

   // Any nonzero digit below the current position
   always_comb begin
      lower_nz = 1'b0;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         if ((2'(i) < pos_ff) && (ent_ff.digit[i] != 4'd0)) begin
            lower_nz = 1'b1;
         end
      end
   end

   // Letter walk and output register
   always_comb begin
      busy_in   = busy_ff;
      ent_in    = ent_ff;
      pos_in    = pos_ff;
      step_in   = step_ff;
      valid_in  = valid_ff && rsp_stall;
      letter_in = letter_ff;
      last_in   = last_ff;
      empty_in  = empty_ff;
      err_in    = err_ff;
      if (pop) begin
         busy_in = 1'b1;
         ent_in  = pop_data;
         pos_in  = 2'd3;
         step_in = 2'd0;
      end else if (busy_ff && out_free) begin
         if (ent_ff.empty || ent_ff.err) begin
            // single flagged beat
            valid_in  = 1'b1;
            letter_in = CHAR_NONE;
            last_in   = 1'b1;
            empty_in  = ent_ff.empty;
            err_in    = ent_ff.err;
            busy_in   = 1'b0;
         end else if (cur_len == 3'd0) begin
            // zero digit: nothing to emit
            if (pos_ff == 2'd0) begin
               busy_in = 1'b0;
            end else begin
               pos_in = pos_ff - 2'd1;
            end
         end else begin
            valid_in  = 1'b1;
            letter_in = letter_code(letter_index(cur_d, step_ff, pos_ff));
            last_in   = digit_end && !lower_nz;
            empty_in  = 1'b0;
            err_in    = 1'b0;
            if (digit_end) begin
               step_in = 2'd0;
               if (!lower_nz) begin
                  busy_in = 1'b0;
               end else begin
                  pos_in = pos_ff - 2'd1;
               end
            end else begin
               step_in = step_ff + 2'd1;
            end
         end
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_letter       = letter_ff;
   assign rsp_last         = last_ff;
   assign rsp_empty_res    = empty_ff;
   assign rsp_out_of_range = err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
      ent_ff    <= ent_in;
      pos_ff    <= pos_in;
      step_ff   <= step_in;
      letter_ff <= letter_in;
      last_ff   <= last_in;
      empty_ff  <= empty_in;
      err_ff    <= err_in;
   end

endmodule
`default_nettype wire
